// ===== rtl/utd_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package utd_pkg;

    // One raw byte of the text stream
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    // One decoded character or replacement
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_used;
        logic        last_of_run;
    } t_out_item;

    localparam logic [20:0] C_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] C_SURR_LO     = 21'h00D800;
    localparam logic [20:0] C_SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] C_CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] C_MIN_LEN4    = 21'h010000;
    localparam logic [20:0] C_MIN_LEN3    = 21'h000800;
    localparam logic [20:0] C_MIN_LEN2    = 21'h000080;

    // Sequence lengths
    localparam logic [2:0] C_LEN_NONE = 3'd0;
    localparam logic [2:0] C_LEN_1    = 3'd1;
    localparam logic [2:0] C_LEN_2    = 3'd2;
    localparam logic [2:0] C_LEN_3    = 3'd3;
    localparam logic [2:0] C_LEN_4    = 3'd4;

endpackage

// ===== rtl/utd_stream_if.sv =====
// Valid/ready stream channel carrying one payload per request.
interface utd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder: one byte per request in, one code point per request out.
// Each input byte is registered, then decoded combinationally against the open
// sequence state into a run of zero to four results held in the result
// register; the output port drains that run at one result per cycle while the
// output is ready, and the final result of a run carries last_of_run. A byte whose
// run has at most one result lets the next byte in, so plain text streams at one
// byte per cycle while the output is ready; a byte that yields more than one result
// (a broken or flushed sequence) holds the input until its run has drained through
// the single result port. A byte that only extends a sequence yields no result.
module utf8_stream_decoder_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utd_stream_if.sink      i_in,
    utd_stream_if.source    o_out
);
    import utd_pkg::*;

    // Input register
    logic       r_s1_valid;
    t_in_item   r_s1_item;

    // Open sequence state
    logic [2:0]  r_seq;
    logic [1:0]  r_held;
    logic [20:0] r_pv;

    // Result run register
    logic        r_run_valid;
    logic [2:0]  r_cnt;
    logic [1:0]  r_idx;
    logic        r_has_main;
    logic [1:0]  r_main_pos;
    logic [20:0] r_main_cp;
    logic [2:0]  r_main_used;

    // Next values from the decode logic
    logic [2:0]  n_seq;
    logic [1:0]  n_held;
    logic [20:0] n_pv;
    logic [2:0]  n_cnt;
    logic        n_has_main;
    logic [1:0]  n_main_pos;
    logic [20:0] n_main_cp;
    logic [2:0]  n_main_used;

    logic        out_last;
    logic        run_done;
    logic        s1_adv;
    logic        in_take;

    // Range checks on a completed multi-byte sequence
    function automatic logic f_value_ok(input logic [2:0] len, input logic [20:0] cp);
        logic ok;
        ok = 1'b0;
        if (len == C_LEN_2) begin
            ok = (cp >= C_MIN_LEN2);
        end else if (len == C_LEN_3) begin
            ok = (cp >= C_MIN_LEN3) && !((cp >= C_SURR_LO) && (cp <= C_SURR_HI));
        end else begin
            ok = (cp >= C_MIN_LEN4) && (cp <= C_CP_MAX);
        end
        return ok;
    endfunction

    // Handshake control
    assign out_last  = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign run_done  = r_run_valid && o_out.ready && out_last;
    assign s1_adv    = r_s1_valid && (!r_run_valid || run_done);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take   = i_in.valid && i_in.ready;

    // Decode one byte against the open sequence
    always_comb begin
        logic [7:0]  b;
        logic [20:0] pv_cat;
        logic [1:0]  held_inc;
        b        = r_s1_item.in_byte;
        pv_cat   = {r_pv[14:0], b[5:0]};
        held_inc = r_held + 2'd1;

        n_seq       = r_seq;
        n_held      = r_held;
        n_pv        = r_pv;
        n_cnt       = 3'd0;
        n_has_main  = 1'b0;
        n_main_pos  = 2'd0;
        n_main_cp   = {13'd0, b};
        n_main_used = C_LEN_1;

        if ((r_seq != C_LEN_NONE) && (b[7:6] == 2'b10)) begin
            // continuation byte: gather, finish when complete
            if (({1'b0, held_inc} + 3'd1) >= r_seq) begin
                if (f_value_ok(r_seq, pv_cat)) begin
                    n_has_main  = 1'b1;
                    n_main_cp   = pv_cat;
                    n_main_used = r_seq;
                    n_cnt       = 3'd1;
                end else begin
                    n_cnt = r_seq;
                end
                n_seq  = C_LEN_NONE;
                n_held = 2'd0;
                n_pv   = 21'd0;
            end else begin
                n_pv   = pv_cat;
                n_held = held_inc;
            end
        end else begin
            // not a continuation: replace lead and held bytes of an open sequence
            if (r_seq != C_LEN_NONE) begin
                n_cnt  = {1'b0, r_held} + 3'd1;
                n_seq  = C_LEN_NONE;
                n_held = 2'd0;
                n_pv   = 21'd0;
            end
            n_main_pos = n_cnt[1:0];
            // decode the byte afresh
            if (!b[7]) begin
                n_has_main = 1'b1;
                n_cnt      = n_cnt + 3'd1;
            end else if (b[7:5] == 3'b110) begin
                n_seq  = C_LEN_2;
                n_held = 2'd0;
                n_pv   = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                n_seq  = C_LEN_3;
                n_held = 2'd0;
                n_pv   = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                n_seq  = C_LEN_4;
                n_held = 2'd0;
                n_pv   = {18'd0, b[2:0]};
            end else begin
                n_cnt = n_cnt + 3'd1;
            end
        end

        // flush an unfinished sequence at end of text
        if (r_s1_item.end_of_text && (n_seq != C_LEN_NONE)) begin
            n_cnt  = n_cnt + {1'b0, n_held} + 3'd1;
            n_seq  = C_LEN_NONE;
            n_held = 2'd0;
            n_pv   = 21'd0;
        end
    end

    // Hold the input byte until the result register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in.payload;
        end
    end

    // Advance the sequence state once per decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= C_LEN_NONE;
            r_held <= 2'd0;
            r_pv   <= 21'd0;
        end else if (s1_adv) begin
            r_seq  <= n_seq;
            r_held <= n_held;
            r_pv   <= n_pv;
        end
    end

    // Load a new run or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_cnt       <= 3'd0;
        end else if (s1_adv) begin
            r_run_valid <= (n_cnt != 3'd0);
            r_idx       <= 2'd0;
            r_cnt       <= n_cnt;
        end else if (run_done) begin
            r_run_valid <= 1'b0;
        end else if (r_run_valid && o_out.ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_has_main  <= n_has_main;
            r_main_pos  <= n_main_pos;
            r_main_cp   <= n_main_cp;
            r_main_used <= n_main_used;
        end
    end

    // Drive the current result of the run
    always_comb begin
        o_out.valid               = r_run_valid;
        o_out.payload.last_of_run = out_last;
        if (r_has_main && (r_idx == r_main_pos)) begin
            o_out.payload.code_point = r_main_cp;
            o_out.payload.bytes_used = r_main_used;
        end else begin
            o_out.payload.code_point = C_REPLACEMENT;
            o_out.payload.bytes_used = C_LEN_1;
        end
    end

endmodule

// ===== rtl/utd_checker.sv =====
// Port-level checks on the UTF-8 stream decoder, bound to its top level.
module utd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  utd_pkg::t_out_item  i_out_item
);
    import utd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("stalled result changed");

    // Keep every result within the code point range with a legal length
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.code_point <= C_CP_MAX)
                        && (i_out_item.bytes_used >= C_LEN_1)
                        && (i_out_item.bytes_used <= C_LEN_4))
        else $error("result out of range");

    // Reject overlong ASCII: a value below 0x80 must use one byte
    a_out_shortest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.code_point < C_MIN_LEN2) |-> i_out_item.bytes_used == C_LEN_1)
        else $error("ASCII value with more than one byte");

    // Deliver the rest of a run without gaps
    a_run_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_item.last_of_run |=> i_out_valid)
        else $error("run broken before its last result");

    // Accept a request whenever no result is waiting
    a_in_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with no result pending");

endmodule

bind utf8_stream_decoder_top utd_checker u_utd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);
